### design/pad_grid_rotation_mapper_top_defines.svh
// assertion macros for the pad grid rotation mapper
`ifndef PAD_GRID_ROTATION_MAPPER_TOP_DEFINES_SVH
`define PAD_GRID_ROTATION_MAPPER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define PGRM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define PGRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PGRM_ASSERT(lbl, clk, rst, prop, msg)
`define PGRM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### design/pgrm_pkg.sv
// types, codes and constants of the pad grid rotation mapper
`default_nettype none
package pgrm_pkg;

  // input commands
  localparam logic [2:0] CMD_PAD_IN   = 3'd0;
  localparam logic [2:0] CMD_GRID_LED = 3'd1;
  localparam logic [2:0] CMD_COL_LED  = 3'd2;
  localparam logic [2:0] CMD_ROW_LED  = 3'd3;
  localparam logic [2:0] CMD_ALL_OFF  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_ROT0   = 3'd1;
  localparam logic [2:0] REG_ROT1   = 3'd2;
  localparam logic [2:0] REG_ROT2   = 3'd3;
  localparam logic [2:0] REG_ROT3   = 3'd4;

  // rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // message bytes
  localparam logic [3:0] TYPE_NOTE   = 4'h9;
  localparam logic [3:0] TYPE_CTRL   = 4'hB;
  localparam logic [7:0] STATUS_NOTE = 8'h90;
  localparam logic [7:0] STATUS_CTRL = 8'hB0;
  localparam logic [3:0] SIDE_LO     = 4'h8;
  localparam logic [4:0] TOP_CC_HI   = 5'b01101;
  localparam logic [6:0] TOP_BASE    = 7'h60;
  localparam logic [1:0] SIDE_HI     = 2'b10;

  // decoded request class
  typedef enum logic [2:0] {
    CLS_GRID_NOTE,
    CLS_SIDE_NOTE,
    CLS_TOP_CC,
    CLS_GRID_LED,
    CLS_COL_LED,
    CLS_ROW_LED,
    CLS_ALL_OFF
  } cls_t;

  function automatic logic [5:0] colour_of(input logic [1:0] state);
    logic [5:0] c;
    case (state)
      2'd0:    c = 6'h00;
      2'd1:    c = 6'h3C;
      2'd2:    c = 6'h0F;
      default: c = 6'h3F;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### design/pad_grid_rotation_mapper_top.sv
// pad grid rotation mapper: three-stage request decode and mapping pipeline
// One request is taken per cycle while busy is low and its results appear
// on the result ports once it has passed the capture, decode and output
// registers, each for one cycle marked by strobe. An all-off request
// gives four results on consecutive cycles (pads 0 to 3, last on the
// final one); while they leave the output register the pipeline holds and
// busy stays high until the last result is on the ports. Requests that map to nothing give no
// strobe. Results cannot be held off, so nothing downstream ever stalls
// the pipeline.
`default_nettype none
`include "pad_grid_rotation_mapper_top_defines.svh"
module pad_grid_rotation_mapper_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [1:0] cfg_data,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] command,
  input  wire logic [1:0] device_index,
  input  wire logic [7:0] status_byte,
  input  wire logic [7:0] data_first,
  input  wire logic [7:0] data_second,
  input  wire logic [7:0] led_x,
  input  wire logic [7:0] led_y,
  input  wire logic [1:0] led_state,
  output logic            strobe,
  output logic            kind,
  output logic [3:0]      grid_row,
  output logic [6:0]      grid_col,
  output logic [7:0]      velocity,
  output logic [1:0]      pad_index,
  output logic [7:0]      midi_status,
  output logic [6:0]      midi_note,
  output logic [5:0]      midi_value,
  output logic            last
);
  import pgrm_pkg::*;

  // configuration
  logic       enabled;
  logic [1:0] rotation [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      for (int i = 0; i < 4; i++) rotation[i] <= ROT_0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: enabled     <= cfg_data[0];
        REG_ROT0:   rotation[0] <= cfg_data;
        REG_ROT1:   rotation[1] <= cfg_data;
        REG_ROT2:   rotation[2] <= cfg_data;
        REG_ROT3:   rotation[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall while the four results of an all-off request leave the output register
  logic       v3;
  logic       alloff3;
  logic [1:0] cnt;
  logic       stall;
  logic       adv;

  assign stall = v3 && alloff3 && (cnt != 2'd3);
  assign adv   = !stall;
  assign busy  = stall;

  // stage 1: request capture
  logic       v1;
  logic [2:0] cmd1;
  logic [1:0] dev1;
  logic [7:0] st1, b11, b21, x1, y1;
  logic [1:0] ls1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1 <= command;
      dev1 <= device_index;
      st1  <= status_byte;
      b11  <= data_first;
      b21  <= data_second;
      x1   <= led_x;
      y1   <= led_y;
      ls1  <= led_state;
    end
  end

  // stage 2: decode, range checks, rotation lookup
  logic       hit;
  cls_t       cls_next;
  logic [1:0] pad_next;
  logic [2:0] p_next, q_next;

  always_comb begin
    hit      = 1'b0;
    cls_next = CLS_ALL_OFF;
    pad_next = dev1;
    p_next   = b11[6:4];
    q_next   = b11[2:0];
    case (cmd1)
      CMD_PAD_IN: begin
        if (st1[3:0] == 4'h0 && !b11[7]) begin
          if (st1[7:4] == TYPE_NOTE) begin
            if (b11[3:0] == SIDE_LO) begin
              hit      = 1'b1;
              cls_next = CLS_SIDE_NOTE;
            end else if (!b11[3]) begin
              hit      = 1'b1;
              cls_next = CLS_GRID_NOTE;
            end
          end else if (st1[7:4] == TYPE_CTRL && b11[7:3] == TOP_CC_HI) begin
            hit      = 1'b1;
            cls_next = CLS_TOP_CC;
            p_next   = b11[2:0];
          end
        end
      end
      CMD_GRID_LED: begin
        hit      = (x1[7:4] == 4'h0) && (y1[7:4] == 4'h0);
        cls_next = CLS_GRID_LED;
        pad_next = {y1[3], x1[3]};
        p_next   = x1[2:0];
        q_next   = y1[2:0];
      end
      CMD_COL_LED: begin
        hit      = (x1[7:1] == 7'h00) && (y1[7:4] == 4'h0);
        cls_next = CLS_COL_LED;
        pad_next = {y1[3], x1[0]};
        p_next   = y1[2:0];
      end
      CMD_ROW_LED: begin
        hit      = (x1[7:4] == 4'h0) && (y1[7:1] == 7'h00);
        cls_next = CLS_ROW_LED;
        pad_next = {y1[0], x1[3]};
        p_next   = x1[2:0];
      end
      CMD_ALL_OFF: begin
        hit      = 1'b1;
        cls_next = CLS_ALL_OFF;
      end
      default: hit = 1'b0;
    endcase
  end

  logic       v2;
  cls_t       cls2;
  logic [1:0] pad2, rot2;
  logic [2:0] p2, q2;
  logic [7:0] vel2;
  logic [5:0] colour2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1 && hit && enabled;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls2    <= cls_next;
      pad2    <= pad_next;
      rot2    <= rotation[pad_next];
      p2      <= p_next;
      q2      <= q_next;
      vel2    <= b21;
      colour2 <= colour_of(ls1);
    end
  end

  // stage 3: rotation and output formatting
  logic       kind_next;
  logic [3:0] row_next;
  logic [6:0] col_next;
  logic [7:0] status_next;
  logic [6:0] note_next;
  logic [6:0] side_col, top_base;
  logic [6:0] side_note_p, side_note_np, top_note_p, top_note_np;

  assign side_col     = {SIDE_HI, pad2[0], 4'h0};
  assign top_base     = TOP_BASE + {2'b00, ({1'b0, pad2[0]} + {1'b0, pad2[1]}), 3'b000};
  assign side_note_p  = {p2, SIDE_LO};
  assign side_note_np = {~p2, SIDE_LO};
  assign top_note_p   = {TOP_CC_HI[3:0], p2};
  assign top_note_np  = {TOP_CC_HI[3:0], ~p2};

  always_comb begin
    kind_next   = 1'b0;
    row_next    = 4'h0;
    col_next    = 7'h00;
    status_next = 8'h00;
    note_next   = 7'h00;
    case (cls2)
      CLS_GRID_NOTE: begin
        // p is the pad row, q the pad column
        case (rot2)
          ROT_0: begin
            row_next = {pad2[1], p2};
            col_next = {3'b000, pad2[0], q2};
          end
          ROT_90: begin
            row_next = {pad2[0], q2};
            col_next = {3'b000, pad2[1], ~p2};
          end
          ROT_180: begin
            row_next = {pad2[1], ~p2};
            col_next = {3'b000, pad2[0], ~q2};
          end
          default: begin
            row_next = {pad2[0], ~q2};
            col_next = {3'b000, pad2[1], p2};
          end
        endcase
      end
      CLS_SIDE_NOTE: begin
        case (rot2)
          ROT_0:   begin row_next = {pad2[1], p2};  col_next = side_col; end
          ROT_90:  col_next = top_base + {4'h0, ~p2};
          ROT_180: begin row_next = {pad2[1], ~p2}; col_next = side_col; end
          default: col_next = top_base + {4'h0, p2};
        endcase
      end
      CLS_TOP_CC: begin
        case (rot2)
          ROT_0:   col_next = top_base + {4'h0, p2};
          ROT_90:  begin row_next = {pad2[1], p2};  col_next = side_col; end
          ROT_180: col_next = top_base + {4'h0, ~p2};
          default: begin row_next = {pad2[1], ~p2}; col_next = side_col; end
        endcase
      end
      CLS_GRID_LED: begin
        // p is the column, q the row inside the pad
        kind_next   = 1'b1;
        status_next = STATUS_NOTE;
        case (rot2)
          ROT_0:   note_next = {q2, 1'b0, p2};
          ROT_90:  note_next = {~p2, 1'b0, q2};
          ROT_180: note_next = {~q2, 1'b0, ~p2};
          default: note_next = {p2, 1'b0, ~q2};
        endcase
      end
      CLS_COL_LED: begin
        kind_next = 1'b1;
        case (rot2)
          ROT_0:   begin status_next = STATUS_NOTE; note_next = side_note_p;  end
          ROT_90:  begin status_next = STATUS_CTRL; note_next = top_note_p;   end
          ROT_180: begin status_next = STATUS_NOTE; note_next = side_note_np; end
          default: begin status_next = STATUS_CTRL; note_next = top_note_np;  end
        endcase
      end
      CLS_ROW_LED: begin
        kind_next = 1'b1;
        case (rot2)
          ROT_0:   begin status_next = STATUS_CTRL; note_next = top_note_p;   end
          ROT_90:  begin status_next = STATUS_NOTE; note_next = side_note_np; end
          ROT_180: begin status_next = STATUS_CTRL; note_next = top_note_np;  end
          default: begin status_next = STATUS_NOTE; note_next = side_note_p;  end
        endcase
      end
      default: begin
        kind_next   = 1'b1;
        status_next = STATUS_CTRL;
      end
    endcase
  end

  logic       led3;
  logic [3:0] row3;
  logic [6:0] col3;
  logic [7:0] vel3;
  logic [1:0] pad3;
  logic [7:0] status3;
  logic [6:0] note3;
  logic [5:0] value3;
  logic       is_led2;

  assign is_led2 = (cls2 == CLS_GRID_LED) || (cls2 == CLS_COL_LED) || (cls2 == CLS_ROW_LED);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3      <= 1'b0;
      alloff3 <= 1'b0;
      cnt     <= 2'd0;
    end else begin
      if (adv) begin
        v3      <= v2;
        alloff3 <= (cls2 == CLS_ALL_OFF);
      end
      if (v3 && alloff3) cnt <= cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      led3    <= kind_next;
      row3    <= row_next;
      col3    <= col_next;
      vel3    <= kind_next ? 8'h00 : vel2;
      pad3    <= kind_next ? pad2 : 2'd0;
      status3 <= status_next;
      note3   <= note_next;
      value3  <= is_led2 ? colour2 : 6'h00;
    end
  end

  assign strobe      = v3;
  assign kind        = led3;
  assign grid_row    = row3;
  assign grid_col    = col3;
  assign velocity    = vel3;
  assign pad_index   = alloff3 ? cnt : pad3;
  assign midi_status = status3;
  assign midi_note   = note3;
  assign midi_value  = value3;
  assign last        = alloff3 ? (cnt == 2'd3) : 1'b1;

  // busy only while an all-off burst is leaving
  `PGRM_ASSERT(a_busy_emits, clk, rst, busy |-> strobe, "busy without a result on the ports")
  // a burst never breaks before its last result
  `PGRM_ASSERT(a_burst_cont, clk, rst, (strobe && !last) |=> strobe, "result burst interrupted")
  // the burst walks through pads in order
  `PGRM_ASSERT(a_burst_order, clk, rst, stall |=> (cnt == $past(cnt) + 2'd1),
               "all-off pad counter skipped")
  // a stall holds the decode stage
  `PGRM_ASSERT(a_stall_hold, clk, rst, stall |=> ($stable(v2) && $stable(pad2)),
               "pipeline moved during a stall")
  `PGRM_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !strobe, "result right after reset")

endmodule
`default_nettype wire
